[rtl/grid_line_point_generator_top_assert.svh]
// Assertion macros used by the line generator datapath.
`ifndef GRID_LINE_POINT_GENERATOR_TOP_ASSERT_SVH
`define GRID_LINE_POINT_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GLPG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glpg: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GLPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glpg: next-cycle check failed");

`endif

[rtl/glpg_pkg.sv]
// Package for the grid line generator: constants, beat types, control types.
`default_nettype none
package glpg_pkg;

   localparam int GRID_X_LIMIT = 17;
   localparam int GRID_Y_LIMIT = 13;
   localparam int MAX_RESULTS  = 16;

   localparam int COORD_W = 5;
   localparam int ROW_OUT_W = 4;
   localparam int LIM_W = 7;
   localparam int ERR_W = COORD_W + 3;
   localparam int CNT_W = $clog2(MAX_RESULTS);

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_col;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] end_col;
      logic [COORD_W-1:0] end_row;
   } req_beat_type;

   typedef struct packed {
      logic [COORD_W-1:0]   cell_col;
      logic [ROW_OUT_W-1:0] cell_row;
      logic                 last_cell;
   } rsp_beat_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic line_ok;
      logic slot_free;
      logic at_end;
      logic at_cap;
   } status_type;

endpackage
`default_nettype wire

[rtl/glpg_ctrl.sv]
// Control state machine of the grid line generator.
`default_nettype none
module glpg_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire glpg_pkg::status_type sts,
   output glpg_pkg::cmd_type       cmd
);
   import glpg_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && sts.line_ok) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (sts.at_end || sts.at_cap) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/glpg_datapath.sv]
// Walk registers, Bresenham step logic and output register of the line generator.
`default_nettype none
`include "grid_line_point_generator_top_assert.svh"
module glpg_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire glpg_pkg::req_beat_type req_beat,
   input  wire glpg_pkg::cmd_type     cmd,
   output glpg_pkg::status_type       sts,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output glpg_pkg::rsp_beat_type     rsp_beat
);
   import glpg_pkg::*;

   coord_type x_ff, y_ff, goal_col_ff, goal_row_ff, span_col_ff, span_row_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic col_neg_ff, row_neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic rsp_valid_ff;
   rsp_beat_type rsp_beat_ff;

   coord_type dx_in, dy_in;
   logic signed [ERR_W-1:0] err_in;
   logic signed [ERR_W:0] e2, neg_dy, dx_ext;
   logic step_x, step_y;
   logic start_on, end_on, same_cell;

   // Endpoint checks on the incoming beat
   always_comb begin
      start_on = ({2'b0, req_beat.start_col} >= LIM_W'(1))
              && ({2'b0, req_beat.start_col} < LIM_W'(GRID_X_LIMIT))
              && ({2'b0, req_beat.start_row} >= LIM_W'(1))
              && ({2'b0, req_beat.start_row} < LIM_W'(GRID_Y_LIMIT));
      end_on   = ({2'b0, req_beat.end_col} >= LIM_W'(1))
              && ({2'b0, req_beat.end_col} < LIM_W'(GRID_X_LIMIT))
              && ({2'b0, req_beat.end_row} >= LIM_W'(1))
              && ({2'b0, req_beat.end_row} < LIM_W'(GRID_Y_LIMIT));
      same_cell = (req_beat.start_col == req_beat.end_col)
               && (req_beat.start_row == req_beat.end_row);
      dx_in = (req_beat.end_col > req_beat.start_col)
            ? req_beat.end_col - req_beat.start_col
            : req_beat.start_col - req_beat.end_col;
      dy_in = (req_beat.end_row > req_beat.start_row)
            ? req_beat.end_row - req_beat.start_row
            : req_beat.start_row - req_beat.end_row;
   end

   // One Bresenham step from the current cell
   always_comb begin
      e2     = {err_ff, 1'b0};
      neg_dy = -$signed({4'b0, span_row_ff});
      dx_ext = $signed({4'b0, span_col_ff});
      step_x = e2 > neg_dy;
      step_y = e2 < dx_ext;
      err_in = err_ff
             - (step_x ? $signed({3'b0, span_row_ff}) : ERR_W'(0))
             + (step_y ? $signed({3'b0, span_col_ff}) : ERR_W'(0));
   end

   always_comb begin
      sts.line_ok   = start_on && end_on && !same_cell;
      sts.slot_free = !rsp_valid_ff || !rsp_stall;
      sts.at_end    = (x_ff == goal_col_ff) && (y_ff == goal_row_ff);
      sts.at_cap    = (cnt_ff == CNT_W'(MAX_RESULTS - 1));
   end

   // Walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff        <= req_beat.start_col;
         y_ff        <= req_beat.start_row;
         goal_col_ff <= req_beat.end_col;
         goal_row_ff <= req_beat.end_row;
         span_col_ff <= dx_in;
         span_row_ff <= dy_in;
         col_neg_ff  <= !(req_beat.start_col < req_beat.end_col);
         row_neg_ff  <= !(req_beat.start_row < req_beat.end_row);
         err_ff      <= $signed({3'b0, dx_in}) - $signed({3'b0, dy_in});
         cnt_ff      <= '0;
      end else if (cmd.emit) begin
         if (step_x) begin
            x_ff <= col_neg_ff ? x_ff - COORD_W'(1) : x_ff + COORD_W'(1);
         end
         if (step_y) begin
            y_ff <= row_neg_ff ? y_ff - COORD_W'(1) : y_ff + COORD_W'(1);
         end
         err_ff <= err_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Output register: holds a beat until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_beat_ff.cell_col  <= x_ff;
         rsp_beat_ff.cell_row  <= y_ff[ROW_OUT_W-1:0];
         rsp_beat_ff.last_cell <= sts.at_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   `GLPG_ASSERT_NOW(a_emit_into_free_slot, clock, reset, cmd.emit, sts.slot_free)
   `GLPG_ASSERT_NEXT(a_emit_shows_beat, clock, reset, cmd.emit, rsp_valid_ff)
   `GLPG_ASSERT_NEXT(a_hold_beat, clock, reset, rsp_valid_ff && rsp_stall, $stable(rsp_beat_ff))
   `GLPG_ASSERT_NOW(a_load_not_emit, clock, reset, cmd.load, !cmd.emit)

endmodule
`default_nettype wire

[rtl/grid_line_point_generator_top.sv]
// Top level of the grid line generator: controller plus datapath.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | start and end cell
//   rsp     | out       | rsp_valid/rsp_stall  | one line cell, last marker
//
// A line is accepted in the idle state and then walked one cell per cycle,
// unless the output stalls, out of the step unit into the output register.
// Lines with equal endpoints or an endpoint off the grid give no beats.
// Reset is synchronous and returns the controller to idle with no beat shown.
// A stalled output holds the current cell and pauses the walk; a new request
// is taken as soon as the walk ends, while the final beat may still wait.
`default_nettype none
module grid_line_point_generator_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire glpg_pkg::req_beat_type req_beat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output glpg_pkg::rsp_beat_type      rsp_beat
);
   import glpg_pkg::*;

   cmd_type    cmd;
   status_type sts;

   glpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   glpg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_beat  (req_beat),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule
`default_nettype wire

[sim/glpg_line_checker.sv]
// Line checker for the grid line generator: predicts line cells and checks every rsp beat.
module glpg_line_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire glpg_pkg::req_beat_type req_beat,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire glpg_pkg::rsp_beat_type rsp_beat,
   output int                          fail_count,
   output int                          beats_owed
);
   import glpg_pkg::*;

   // Cells still owed by the block, oldest first.
   rsp_beat_type cells_owed[$];
   int           faults = 0;

   function automatic bit cell_on_grid(input coord_type col, input coord_type row);
      return col >= 1 && col < GRID_X_LIMIT && row >= 1 && row < GRID_Y_LIMIT;
   endfunction

   // Walk the Bresenham line of one request and queue its cells.
   function automatic void plot_line(input req_beat_type seg);
      int           x, y, gx, gy, dx, dy, sx, sy, err, e2;
      rsp_beat_type cell_exp;
      if (seg.start_col == seg.end_col && seg.start_row == seg.end_row) return;
      if (!cell_on_grid(seg.start_col, seg.start_row) ||
          !cell_on_grid(seg.end_col, seg.end_row)) return;
      x  = seg.start_col;
      y  = seg.start_row;
      gx = seg.end_col;
      gy = seg.end_row;
      dx = gx > x ? gx - x : x - gx;
      dy = gy > y ? gy - y : y - gy;
      sx = x < gx ? 1 : -1;
      sy = y < gy ? 1 : -1;
      err = dx - dy;
      for (int n = 0; n < MAX_RESULTS; n++) begin
         cell_exp.cell_col  = x[COORD_W-1:0];
         cell_exp.cell_row  = y[ROW_OUT_W-1:0];
         cell_exp.last_cell = (x == gx && y == gy);
         cells_owed.push_back(cell_exp);
         if (cell_exp.last_cell) break;
         // both axes may step in the same cell
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            x += sx;
         end
         if (e2 < dx) begin
            err += dx;
            y += sy;
         end
      end
   endfunction

   // Compare each accepted beat with the oldest owed cell, then queue new lines.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         cells_owed.delete();
         faults = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cells_owed.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("unexpected cell beat: col %0d row %0d last %0b",
                           rsp_beat.cell_col, rsp_beat.cell_row, rsp_beat.last_cell);
            end else begin
               want = cells_owed.pop_front();
               if (rsp_beat.cell_col !== want.cell_col ||
                   rsp_beat.cell_row !== want.cell_row ||
                   rsp_beat.last_cell !== want.last_cell) begin
                  faults++;
                  if (faults <= 10)
                     $display({"cell mismatch: expected col %0d row %0d last %0b, ",
                               "got col %0d row %0d last %0b"},
                              want.cell_col, want.cell_row, want.last_cell,
                              rsp_beat.cell_col, rsp_beat.cell_row, rsp_beat.last_cell);
               end
            end
         end
         if (req_valid && !req_stall) plot_line(req_beat);
      end
      fail_count <= faults;
      beats_owed <= cells_owed.size();
   end

endmodule

[sim/grid_line_point_generator_top_test.sv]
// Testbench top for the grid line generator: clock, reset, line requests, verdict.
module grid_line_point_generator_top_test;
   import glpg_pkg::*;

   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 40;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_beat  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b1;
   rsp_beat_type rsp_beat;

   int fail_count;
   int beats_owed;
   bit tx_busy         = 1'b1;
   bit rx_busy         = 1'b1;
   bit long_hold_asked = 1'b0;

   grid_line_point_generator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   glpg_line_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_beat   (rsp_beat),
      .fail_count (fail_count),
      .beats_owed (beats_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit, well above the slowest legal run.
   initial begin
      #6000000;
      $display("FAIL");
      $finish;
   end

   // Result side: random stall per beat, idle-free stretches, one long hold-off.
   initial begin : receiver
      int hold;
      wait (!reset);
      forever begin
         if (long_hold_asked) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_asked = 1'b0;
         end
         if ($urandom_range(0, 39) == 0) rx_busy = ~rx_busy;
         hold = rx_busy ? $urandom_range(0, 18) : 0;
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Offer one line request, after a random gap while tx_busy is set; return once the beat is taken.
   task automatic offer_line(input int sc, input int sr, input int ec, input int er);
      int gap;
      gap = tx_busy ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_beat.start_col = sc[COORD_W-1:0];
      req_beat.start_row = sr[COORD_W-1:0];
      req_beat.end_col   = ec[COORD_W-1:0];
      req_beat.end_row   = er[COORD_W-1:0];
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed cell has come out.
   task automatic drain_lines();
      req_valid = 1'b0;
      while (beats_owed != 0) @(negedge clock);
   endtask

   // Random lines: mostly on-grid endpoints, some noise over the whole field range.
   task automatic random_lines(input int count);
      int sc, sr, ec, er, drawn;
      drawn = 0;
      while (drawn < count) begin
         if ($urandom_range(0, 29) == 0) tx_busy = ~tx_busy;
         if ($urandom_range(0, 9) < 8) begin
            sc = $urandom_range(1, GRID_X_LIMIT - 1);
            sr = $urandom_range(1, GRID_Y_LIMIT - 1);
            ec = $urandom_range(1, GRID_X_LIMIT - 1);
            er = $urandom_range(1, GRID_Y_LIMIT - 1);
         end else begin
            sc = $urandom_range(0, 31);
            sr = $urandom_range(0, 31);
            ec = $urandom_range(0, 31);
            er = $urandom_range(0, 31);
         end
         offer_line(sc, sr, ec, er);
         // only lines that give cells count
         if (!(sc == ec && sr == er) &&
             sc >= 1 && sc < GRID_X_LIMIT && sr >= 1 && sr < GRID_Y_LIMIT &&
             ec >= 1 && ec < GRID_X_LIMIT && er >= 1 && er < GRID_Y_LIMIT)
            drawn++;
      end
   endtask

   initial begin : stimulus
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed lines: grid corners, axes, diagonals, degenerate and off-grid ends.
      offer_line(0, 0, 0, 0);
      offer_line(31, 31, 31, 31);
      offer_line(1, 1, 16, 12);
      offer_line(16, 12, 1, 1);
      offer_line(1, 12, 16, 1);
      offer_line(16, 1, 1, 12);
      offer_line(1, 6, 16, 6);
      offer_line(8, 12, 8, 1);
      offer_line(3, 3, 10, 10);
      offer_line(5, 5, 5, 5);
      offer_line(0, 5, 8, 5);
      offer_line(17, 5, 8, 5);
      offer_line(5, 0, 8, 5);
      offer_line(5, 13, 8, 5);
      offer_line(4, 4, 20, 4);
      offer_line(4, 4, 4, 31);
      offer_line(1, 1, 2, 1);
      offer_line(2, 2, 1, 3);
      offer_line(2, 1, 5, 12);
      offer_line(16, 12, 15, 12);
      offer_line(31, 0, 1, 1);
      offer_line(10, 7, 3, 9);
      drain_lines();

      // Long result hold-off while requests keep coming, so the input backs up.
      long_hold_asked = 1'b1;
      random_lines(95);
      drain_lines();

      random_lines(95);
      drain_lines();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && beats_owed == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
